@@ design/m4mul_pkg.sv @@
`default_nettype none

package m4mul_pkg;

  // default sizes and fixed field widths
  localparam int DimDef       = 4;
  localparam int ElemWidthDef = 32;
  localparam int FracBits     = 16;
  localparam int ModeW        = 2;
  localparam int IndexW       = 4;
  localparam int ValueW       = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_MULT   = 2'd2
  } m4mul_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } m4mul_state_t;

  // controller to datapath
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic issue;
    logic first;
    logic emit;
    logic last;
  } m4mul_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } m4mul_sts_t;

endpackage

`default_nettype wire

@@ design/m4mul_if.sv @@
`default_nettype none

interface m4mul_in_if import m4mul_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [IndexW-1:0] element_index;
  logic [ValueW-1:0] element_value;

  modport source (output valid, output mode, output element_index, output element_value,
                  input ready);
  modport sink (input valid, input mode, input element_index, input element_value,
                output ready);
endinterface

interface m4mul_out_if import m4mul_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] result_index;
  logic [ValueW-1:0] result_value;
  logic              last;

  modport source (output valid, output result_index, output result_value, output last,
                  input ready);
  modport sink (input valid, input result_index, input result_value, input last,
                output ready);
endinterface

`default_nettype wire

@@ design/matrix4_multiply.sv @@
`default_nettype none

// channel   dir  handshake      payload
// in_chan   in   valid/ready    mode[1:0], element_index[3:0], element_value[31:0]
// out_chan  out  valid/ready    result_index[3:0], result_value[31:0], last
//
// a load item writes one element of the a or b matrix ram; an index past the last cell is dropped
// a multiply item reads, for each result, DIM pairs through the single
// multiply-accumulate, one pair per cycle, then drains the ram read and
// multiplier stages, then does one emit
// rst_n is synchronous active low; matrix contents are undefined until written
// a stalled out_chan holds the result register and the sequencer waits in emit;
// new items are taken while the last result is still waiting
module matrix4_multiply import m4mul_pkg::*; #(
  parameter int DIM        = DimDef,
  parameter int ELEM_WIDTH = ElemWidthDef
) (
  input wire logic  clk,
  input wire logic  rst_n,
  m4mul_in_if.sink    in_chan,
  m4mul_out_if.source out_chan
);

  localparam int AW = $clog2(DIM*DIM);

  m4mul_cmd_t        cmd;
  m4mul_sts_t        sts;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [IndexW-1:0] res_index;

  // sequencer: load writes, element walk and emit timing
  m4mul_ctrl #(.DIM(DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_ready  (in_chan.ready),
    .sts       (sts),
    .cmd       (cmd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .res_index (res_index)
  );

  // matrix rams, multiplier, accumulator, rounding and the output register
  m4mul_dp #(.DIM(DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr_a        (rd_addr_a),
    .rd_addr_b        (rd_addr_b),
    .res_index        (res_index),
    .in_element_index (in_chan.element_index),
    .in_element_value (in_chan.element_value),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_result_index (out_chan.result_index),
    .out_result_value (out_chan.result_value),
    .out_last         (out_chan.last),
    .sts              (sts)
  );

endmodule

`default_nettype wire

@@ design/m4mul_ram.sv @@
`default_nettype none

module m4mul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/m4mul_ctrl.sv @@
`default_nettype none

module m4mul_ctrl import m4mul_pkg::*; #(
  parameter int DIM = DimDef
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic [ModeW-1:0]                in_mode,
  output logic                                 in_ready,
  input  wire m4mul_sts_t                      sts,
  output m4mul_cmd_t                           cmd,
  output logic      [$clog2(DIM*DIM)-1:0]      rd_addr_a,
  output logic      [$clog2(DIM*DIM)-1:0]      rd_addr_b,
  output logic      [IndexW-1:0]               res_index
);

  localparam int CW = $clog2(DIM);
  localparam int AW = $clog2(DIM*DIM);

  m4mul_state_t state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          k_end, row_end, col_end;
  logic [AW-1:0] pos;
  logic [AW+IndexW-1:0] pos_w;

  assign k_end   = (k_r == CW'(DIM - 1));
  assign row_end = (row_r == CW'(DIM - 1));
  assign col_end = (col_r == CW'(DIM - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_mode == MODE_MULT)) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = (row_end && col_end) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    k_nxt    = k_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        case (in_mode)
          MODE_LOAD_A: cmd.wr_a = in_valid;
          MODE_LOAD_B: cmd.wr_b = in_valid;
          default: ;
        endcase
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.first = (k_r == '0);
        k_nxt     = k_end ? '0 : k_r + CW'(1);
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.last = row_end && col_end;
        if (sts.out_free) begin
          row_nxt = row_end ? '0 : row_r + CW'(1);
          if (row_end) begin
            col_nxt = col_end ? '0 : col_r + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // a entry k*DIM+row, b entry col*DIM+k
  assign rd_addr_a = AW'(k_r) * AW'(DIM) + AW'(row_r);
  assign rd_addr_b = AW'(col_r) * AW'(DIM) + AW'(k_r);
  assign pos       = AW'(col_r) * AW'(DIM) + AW'(row_r);
  assign pos_w     = (AW+IndexW)'(pos);
  assign res_index = pos_w[IndexW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (k_r == '0 && row_r == '0 && col_r == '0))
    else $error("counters not back at zero in idle");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_ready)
    else $error("input accepted while products in flight");

endmodule

`default_nettype wire

@@ design/m4mul_dp.sv @@
`default_nettype none

module m4mul_dp import m4mul_pkg::*; #(
  parameter int DIM        = DimDef,
  parameter int ELEM_WIDTH = ElemWidthDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire m4mul_cmd_t                 cmd,
  input  wire logic [$clog2(DIM*DIM)-1:0] rd_addr_a,
  input  wire logic [$clog2(DIM*DIM)-1:0] rd_addr_b,
  input  wire logic [IndexW-1:0]          res_index,
  input  wire logic [IndexW-1:0]          in_element_index,
  input  wire logic [ValueW-1:0]          in_element_value,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic      [IndexW-1:0]          out_result_index,
  output logic      [ValueW-1:0]          out_result_value,
  output logic                            out_last,
  output m4mul_sts_t                      sts
);

  localparam int Cells = DIM * DIM;
  localparam int AW    = $clog2(Cells);
  localparam int EW    = ELEM_WIDTH;
  localparam int PW    = 2 * EW;
  localparam int ACC_W = PW + $clog2(DIM) + 1;
  localparam int RW    = ACC_W - FracBits;

  logic [AW+IndexW-1:0] widx;
  logic                 idx_ok;
  logic [EW-1:0]        rdata_a, rdata_b;
  logic                 rd_v_r, rd_first_r;
  logic                 prod_v_r, prod_first_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [RW-1:0]    shifted;
  logic                    fits;
  logic signed [EW-1:0]    sat;
  logic                    out_valid_r;
  logic [IndexW-1:0]       res_index_r;
  logic [ValueW-1:0]       res_value_r;
  logic                    last_r;

  assign widx   = (AW+IndexW)'(in_element_index);
  assign idx_ok = (widx < (AW+IndexW)'(Cells));

  m4mul_ram #(.WIDTH(EW), .DEPTH(Cells)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a && idx_ok),
    .waddr (widx[AW-1:0]),
    .wdata (in_element_value[EW-1:0]),
    .re    (cmd.issue),
    .raddr (rd_addr_a),
    .rdata (rdata_a)
  );

  m4mul_ram #(.WIDTH(EW), .DEPTH(Cells)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b && idx_ok),
    .waddr (widx[AW-1:0]),
    .wdata (in_element_value[EW-1:0]),
    .re    (cmd.issue),
    .raddr (rd_addr_b),
    .rdata (rdata_b)
  );

  // round half up, then clamp to the element range
  assign rnd_sum = acc_r + (ACC_W'(1) <<< (FracBits - 1));
  assign shifted = rnd_sum[ACC_W-1:FracBits];
  assign fits    = (&shifted[RW-1:EW-1]) || !(|shifted[RW-1:EW-1]);
  assign sat     = fits ? shifted[EW-1:0]
                 : (shifted[RW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r   <= cmd.first;
    prod_first_r <= rd_first_r;
    if (rd_v_r) begin
      prod_r <= PW'(signed'(rdata_a)) * PW'(signed'(rdata_b));
    end
    if (prod_v_r) begin
      acc_r <= prod_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    if (cmd.emit) begin
      res_index_r <= res_index;
      res_value_r <= ValueW'(sat);
      last_r      <= cmd.last;
    end
  end

  assign sts.busy         = rd_v_r || prod_v_r;
  assign sts.out_free     = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_result_index = res_index_r;
  assign out_result_value = res_value_r;
  assign out_last         = last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_emit_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!rd_v_r && !prod_v_r && !cmd.issue))
    else $error("result emitted while sum still in flight");

endmodule

`default_nettype wire
